[rtl/beq_pkg.sv]
// ----------------------------------------------------------------------------
// beq_pkg
// Shared types, codes and the elevator ordering for the request queue block.
// ----------------------------------------------------------------------------
package beq_pkg;

    // function codes of an input request
    localparam logic FUNC_SUBMIT   = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    // command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // result status codes
    localparam logic [2:0] ST_QUEUED = 3'd0;
    localparam logic [2:0] ST_ISSUED = 3'd1;
    localparam logic [2:0] ST_NO_IO  = 3'd2;
    localparam logic [2:0] ST_NO_DEV = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    // one stored disk request; field order gives the elevator key
    typedef struct packed {
        logic        cmd;
        logic [15:0] device;
        logic [33:0] sector;
        logic [15:0] tag;
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WHEAD,
        S_WCMP,
        S_INS_NEW,
        S_INS_CUR,
        S_CHEAD,
        S_CNEXT,
        S_RESULT
    } t_state;

    // true when request a goes strictly before b: read first, then device, then sector
    function automatic logic goes_before(input t_req a, input t_req b);
        logic [50:0] ka;
        logic [50:0] kb;
        ka = {a.cmd, a.device, a.sector};
        kb = {b.cmd, b.device, b.sector};
        return ka < kb;
    endfunction

endpackage

[rtl/beq_slot_ram.sv]
// ----------------------------------------------------------------------------
// beq_slot_ram
// Slot record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module beq_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 74
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/block_request_elevator_queue.sv]
// ----------------------------------------------------------------------------
// block_request_elevator_queue
// Pool of request slots shared by per-major-number queues kept as linked lists,
// with elevator ordering on insert and head issue on complete.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------
//  request   in         i_valid / o_stall      i_func i_cmd i_device_number ...
//  result    out        o_valid / i_stall      o_status o_slot_index o_issue_*
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (device present mask)
//
//  Steps: a complete decodes, reads the queue head, reads the next entry if
//  there is one, then gives its result. A submit decodes, scans for a free
//  slot (one slot a cycle, up to SLOTS), then for a non-empty queue walks the
//  list one entry a cycle and does two write-backs. The slot memory's
//  registered read sets the walk rate.
//  Reset clears slot busy bits, queue head valid bits and the mask; no clearing pass.
//  A finished result waits in the output register while the next request is
//  taken; the block stalls requests while one is in work.
//
module block_request_elevator_queue #(
    parameter int SLOTS  = 32,
    parameter int MAJORS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic        i_cmd,
    input  logic [15:0] i_device_number,
    input  logic [31:0] i_block_number,
    input  logic        i_buffer_valid,
    input  logic        i_buffer_dirty,
    input  logic [15:0] i_buffer_tag,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot_index,
    output logic        o_issue_valid,
    output logic        o_issue_cmd,
    output logic [15:0] o_issue_device,
    output logic [33:0] o_issue_sector,
    output logic [15:0] o_issue_tag,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int SW    = $clog2(SLOTS);
    localparam int MW    = (MAJORS > 1) ? $clog2(MAJORS) : 1;
    localparam int REQ_W = $bits(beq_pkg::t_req);
    localparam int RAM_W = REQ_W + 1 + SW;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    // control state
    beq_pkg::t_state     r_state, n_state;
    logic [SLOTS-1:0]    r_busy;
    logic [MAJORS-1:0]   r_head_vld;
    logic [SW-1:0]       r_head [MAJORS];
    logic [7:0]          r_mask;
    logic                r_o_valid;

    // request being worked on
    logic                r_func;
    beq_pkg::t_req       r_req;
    logic                r_bv;
    logic                r_bd;
    logic [SW-1:0]       r_idx;
    logic [SW-1:0]       r_cnt;
    logic [SW-1:0]       r_s;

    // walk cursor
    logic [SW-1:0]       r_cur_idx;
    beq_pkg::t_req       r_cur;
    logic                r_cur_null;
    logic [SW-1:0]       r_cur_next;
    logic                r_cur_lt_s;
    logic                r_s_lt_cur;

    // staged result
    logic [2:0]          r_res_status;
    logic [SW-1:0]       r_res_slot;
    logic                r_res_iss;
    beq_pkg::t_req       r_res_req;

    // output register
    logic [2:0]          r_o_status;
    logic [4:0]          r_o_slot;
    logic                r_o_iss;
    beq_pkg::t_req       r_o_req;

    // memory port
    logic                mem_we;
    logic [SW-1:0]       mem_waddr;
    logic [RAM_W-1:0]    mem_wdata;
    logic [SW-1:0]       mem_raddr;
    logic [RAM_W-1:0]    mem_rdata;

    beq_pkg::t_req       rd_req;
    logic                rd_null;
    logic [SW-1:0]       rd_next;
    logic                rd_lt_s;
    logic                s_lt_rd;
    logic                brk;
    logic                in_range;
    logic [MW-1:0]       maj;
    logic                head_vld_m;
    logic [SW-1:0]       head_m;
    logic                no_io;
    logic                out_free;
    logic [SW+4:0]       slot_wide;

    beq_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (RAM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // unpack the record read last cycle
    assign rd_req  = beq_pkg::t_req'(mem_rdata[RAM_W-1 -: REQ_W]);
    assign rd_null = mem_rdata[SW];
    assign rd_next = mem_rdata[SW-1:0];

    // two key compares per cycle: record read vs. new request
    assign rd_lt_s = beq_pkg::goes_before(rd_req, r_req);
    assign s_lt_rd = beq_pkg::goes_before(r_req, rd_req);
    assign brk     = (r_cur_lt_s && s_lt_rd) || (r_s_lt_cur && rd_lt_s);

    assign in_range   = r_req.device[15:8] < 8'(MAJORS);
    assign maj        = r_req.device[8 +: MW];
    assign head_vld_m = r_head_vld[maj];
    assign head_m     = r_head[maj];
    assign no_io      = (r_req.cmd == beq_pkg::CMD_READ && r_bv) ||
                        (r_req.cmd == beq_pkg::CMD_WRITE && !r_bd);
    assign out_free   = !r_o_valid || !i_stall;

    // next state and memory control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_s;
        mem_wdata = {r_req, r_cur_null, r_cur_next};
        mem_raddr = rd_next;
        case (r_state)
            beq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = beq_pkg::S_DECODE;
                end
            end
            beq_pkg::S_DECODE: begin
                if (!in_range) begin
                    n_state = beq_pkg::S_RESULT;
                end else if (r_func == beq_pkg::FUNC_COMPLETE) begin
                    mem_raddr = head_m;
                    n_state   = head_vld_m ? beq_pkg::S_CHEAD : beq_pkg::S_RESULT;
                end else if (!r_mask[r_req.device[10:8]] || no_io) begin
                    n_state = beq_pkg::S_RESULT;
                end else begin
                    n_state = beq_pkg::S_SCAN;
                end
            end
            beq_pkg::S_SCAN: begin
                if (!r_busy[r_idx]) begin
                    if (!head_vld_m) begin
                        // empty queue: store with a null link and issue now
                        mem_we    = 1'b1;
                        mem_waddr = r_idx;
                        mem_wdata = {r_req, 1'b1, {SW{1'b0}}};
                        n_state   = beq_pkg::S_RESULT;
                    end else begin
                        mem_raddr = head_m;
                        n_state   = beq_pkg::S_WHEAD;
                    end
                end else if (r_idx == LAST) begin
                    n_state = beq_pkg::S_RESULT;
                end
            end
            beq_pkg::S_WHEAD: begin
                mem_raddr = rd_next;
                n_state   = rd_null ? beq_pkg::S_INS_NEW : beq_pkg::S_WCMP;
            end
            beq_pkg::S_WCMP: begin
                mem_raddr = rd_next;
                if (brk || rd_null || r_cnt == LAST) begin
                    n_state = beq_pkg::S_INS_NEW;
                end
            end
            beq_pkg::S_INS_NEW: begin
                mem_we    = 1'b1;
                mem_waddr = r_s;
                mem_wdata = {r_req, r_cur_null, r_cur_next};
                n_state   = beq_pkg::S_INS_CUR;
            end
            beq_pkg::S_INS_CUR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur_idx;
                mem_wdata = {r_cur, 1'b0, r_s};
                n_state   = beq_pkg::S_RESULT;
            end
            beq_pkg::S_CHEAD: begin
                mem_raddr = rd_next;
                n_state   = rd_null ? beq_pkg::S_RESULT : beq_pkg::S_CNEXT;
            end
            beq_pkg::S_CNEXT: begin
                n_state = beq_pkg::S_RESULT;
            end
            beq_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = beq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = beq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= beq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers: busy bits, queue head valid bits, mask, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= '0;
            r_head_vld <= '0;
            r_mask     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
            if (r_state == beq_pkg::S_SCAN && !r_busy[r_idx]) begin
                r_busy[r_idx] <= 1'b1;
                if (!head_vld_m) begin
                    r_head_vld[maj] <= 1'b1;
                end
            end
            if (r_state == beq_pkg::S_CHEAD) begin
                r_busy[head_m] <= 1'b0;
                if (rd_null) begin
                    r_head_vld[maj] <= 1'b0;
                end
            end
            if (r_state == beq_pkg::S_RESULT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            beq_pkg::S_IDLE: begin
                if (i_valid) begin
                    r_func <= i_func;
                    r_req  <= '{cmd: i_cmd, device: i_device_number,
                                sector: {i_block_number, 2'b00}, tag: i_buffer_tag};
                    r_bv   <= i_buffer_valid;
                    r_bd   <= i_buffer_dirty;
                    r_idx  <= '0;
                    r_cnt  <= '0;
                end
            end
            beq_pkg::S_DECODE: begin
                r_res_iss  <= 1'b0;
                r_res_slot <= '0;
                if (!in_range) begin
                    r_res_status <= beq_pkg::ST_NO_DEV;
                end else if (r_func == beq_pkg::FUNC_COMPLETE) begin
                    r_res_status <= beq_pkg::ST_EMPTY;
                end else if (!r_mask[r_req.device[10:8]]) begin
                    r_res_status <= beq_pkg::ST_NO_DEV;
                end else begin
                    r_res_status <= no_io ? beq_pkg::ST_NO_IO : beq_pkg::ST_FULL;
                end
            end
            beq_pkg::S_SCAN: begin
                if (!r_busy[r_idx]) begin
                    r_s       <= r_idx;
                    r_cur_idx <= head_m;
                    if (!head_vld_m) begin
                        r_head[maj]  <= r_idx;
                        r_res_status <= beq_pkg::ST_ISSUED;
                        r_res_slot   <= r_idx;
                        r_res_iss    <= 1'b1;
                        r_res_req    <= r_req;
                    end
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            beq_pkg::S_WHEAD: begin
                r_cur      <= rd_req;
                r_cur_null <= rd_null;
                r_cur_next <= rd_next;
                r_cur_lt_s <= rd_lt_s;
                r_s_lt_cur <= s_lt_rd;
            end
            beq_pkg::S_WCMP: begin
                if (!brk) begin
                    // advance the cursor to the entry just read
                    r_cur      <= rd_req;
                    r_cur_null <= rd_null;
                    r_cur_next <= rd_next;
                    r_cur_idx  <= r_cur_next;
                    r_cur_lt_s <= rd_lt_s;
                    r_s_lt_cur <= s_lt_rd;
                    r_cnt      <= r_cnt + 1'b1;
                end
            end
            beq_pkg::S_INS_CUR: begin
                r_res_status <= beq_pkg::ST_QUEUED;
                r_res_slot   <= r_s;
            end
            beq_pkg::S_CHEAD: begin
                r_res_slot <= head_m;
                if (!rd_null) begin
                    r_head[maj] <= rd_next;
                    r_s         <= rd_next;
                end
            end
            beq_pkg::S_CNEXT: begin
                r_res_status <= beq_pkg::ST_ISSUED;
                r_res_slot   <= r_s;
                r_res_iss    <= 1'b1;
                r_res_req    <= rd_req;
            end
            beq_pkg::S_RESULT: begin
                if (out_free) begin
                    r_o_status <= r_res_status;
                    r_o_slot   <= slot_wide[4:0];
                    r_o_iss    <= r_res_iss;
                    r_o_req    <= r_res_iss ? r_res_req : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign slot_wide = {5'b0, r_res_slot};

    assign o_stall        = (r_state != beq_pkg::S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_slot_index   = r_o_slot;
    assign o_issue_valid  = r_o_iss;
    assign o_issue_cmd    = r_o_req.cmd;
    assign o_issue_device = r_o_req.device;
    assign o_issue_sector = r_o_req.sector;
    assign o_issue_tag    = r_o_req.tag;

    // a nonempty queue always owns at least one busy slot
    a_head_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == beq_pkg::S_IDLE && |r_head_vld) |-> |r_busy)
        else $error("queue head present with no busy slot");

    // an issued result carries the issued status
    a_issue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_iss) |-> (r_o_status == beq_pkg::ST_ISSUED))
        else $error("issue flag without issued status");

    // an accepted request starts work at once
    a_accept_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == beq_pkg::S_DECODE))
        else $error("accepted request not decoded");

endmodule
